// ===== sv/erd_pkg.sv =====
package erd_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic        [15:0] intensity_t;
  typedef logic signed [16:0] ramp_t;
  typedef logic signed [15:0] score_t;
  typedef logic        [31:0] count_t;

  localparam int CFG_W = 17;
  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [1:0]       cfg_index_t;

  localparam cfg_index_t REG_ALPHA = 2'd0;
  localparam cfg_index_t REG_SAT   = 2'd1;
  localparam cfg_index_t REG_THR   = 2'd2;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [16:0] ALPHA_RST = 17'd6554;
  localparam logic [15:0] SAT_RST   = 16'd4096;
  localparam logic [15:0] THR_RST   = 16'd410;

  localparam score_t SCORE_MAX = 16'sh7FFF;
  localparam score_t SCORE_MIN = 16'sh8000;

endpackage

// ===== sv/erd_if.sv =====
interface erd_in_if;
  logic             valid;
  logic             ready;
  erd_pkg::sample_t bias_sample;

  modport source (output valid, output bias_sample, input ready);
  modport sink   (input valid, input bias_sample, output ready);
endinterface

interface erd_out_if;
  logic                valid;
  logic                ready;
  erd_pkg::intensity_t intensity;
  erd_pkg::ramp_t      ramp;
  erd_pkg::score_t     slope_score;
  logic                surging;
  logic                fading;
  logic                surge_event;
  logic                fade_event;
  erd_pkg::count_t     sample_count;

  modport source (output valid, output intensity, output ramp, output slope_score,
                  output surging, output fading, output surge_event,
                  output fade_event, output sample_count, input ready);
  modport sink   (input valid, input intensity, input ramp, input slope_score,
                  input surging, input fading, input surge_event,
                  input fade_event, input sample_count, output ready);
endinterface

// ===== sv/ema_ramp_surge_detector_top.sv =====
// Channel   Dir  Handshake              Beat
// in_ch     in   valid/ready            bias_sample (Q4.12 signed)
// out_ch    out  valid/ready            intensity, ramp, slope_score, flags, sample_count
// cfg_*     in   cfg_we (no back-pressure)  cfg_index selects alpha / saturation / threshold
//
// One sample passes through the accept in S_IDLE, the radix-4 serial multiply in S_MUL
// (alpha times the average error, two alpha bits a cycle), ramp and flag forming in
// S_FIN, and the radix-2 divider in S_DIV (two quotient bits a cycle) for the score.
// A new sample is taken once the divider has finished.
// Synchronous reset clears state and loads the register defaults.
// A result waiting in the output register blocks only the last divider cycle.
module ema_ramp_surge_detector_top (
  input  logic                clk,
  input  logic                rst_n,
  erd_in_if.sink              in_ch,
  erd_out_if.source           out_ch,
  input  logic                cfg_we,
  input  erd_pkg::cfg_index_t cfg_index,
  input  erd_pkg::cfg_data_t  cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  localparam logic [3:0] MUL_LAST = 4'd8;
  localparam logic [3:0] DIV_LAST = 4'd7;

  // control and architectural state
  logic [1:0]  state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] alpha_r;
  logic [15:0] sat_r;
  logic [15:0] thr_r;
  logic [15:0] avg_r, avg_nxt;
  logic        seeded_r;
  logic        last_surge_r, last_surge_nxt;
  logic        last_fade_r, last_fade_nxt;
  erd_pkg::count_t obs_r, obs_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath work registers
  logic        [15:0] old_r, old_nxt;
  logic signed [17:0] d_r, d_nxt;
  logic        [17:0] asr_r, asr_nxt;
  logic signed [19:0] acc_hi_r, acc_hi_nxt;
  logic        [2:0]  lo_r, lo_nxt;
  logic        [15:0] rem_r, rem_nxt;
  logic        [15:0] q_r, q_nxt;
  logic               clamp_r, clamp_nxt;
  logic               neg_r, neg_nxt;
  erd_pkg::ramp_t     res_ramp_r, res_ramp_nxt;
  logic               res_surge_r, res_surge_nxt;
  logic               res_fade_r, res_fade_nxt;
  logic               res_sev_r, res_sev_nxt;
  logic               res_fev_r, res_fev_nxt;

  // output register
  erd_pkg::intensity_t out_int_r;
  erd_pkg::ramp_t      out_ramp_r;
  erd_pkg::score_t     out_score_r, out_score_nxt;
  logic                out_surge_r, out_fade_r, out_sev_r, out_fev_r;
  erd_pkg::count_t     out_cnt_r;

  // combinational helpers
  logic               in_acc;
  logic               out_load;
  logic signed [16:0] s_ext;
  logic        [16:0] in_mag;
  logic        [15:0] old_sel;
  logic signed [19:0] d_ext, pd, p;
  logic signed [22:0] pq, pr;
  erd_pkg::ramp_t     ramp_w;
  logic signed [17:0] ramp18, thr18, sum18;
  logic               surge_w, fade_w;
  logic        [16:0] rmag;
  logic        [15:0] sat_eff;
  logic        [16:0] t1, t2, r1, r2;
  logic               b1, b2;
  logic        [15:0] q_fin;
  logic        [16:0] alpha_wr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DIV) && (cnt_r == '0) &&
                       (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.intensity    = out_int_r;
  assign out_ch.ramp         = out_ramp_r;
  assign out_ch.slope_score  = out_score_r;
  assign out_ch.surging      = out_surge_r;
  assign out_ch.fading       = out_fade_r;
  assign out_ch.surge_event  = out_sev_r;
  assign out_ch.fade_event   = out_fev_r;
  assign out_ch.sample_count = out_cnt_r;

  // rectify and form the error against the held average
  always_comb begin
    s_ext   = {in_ch.bias_sample[15], in_ch.bias_sample};
    in_mag  = s_ext[16] ? 17'(-s_ext) : 17'(s_ext);
    old_sel = seeded_r ? avg_r : in_mag[15:0];
  end

  // one radix-4 multiply digit
  always_comb begin
    d_ext = {{2{d_r[17]}}, d_r};
    pd    = (asr_r[0] ? d_ext : 20'sd0) + (asr_r[1] ? (d_ext <<< 1) : 20'sd0);
    p     = acc_hi_r + pd;
  end

  // round half up: floor((P + 2^15) / 2^16) from P >>> 15
  always_comb begin
    pq     = {acc_hi_r, lo_r};
    pr     = (pq + 23'sd1) >>> 1;
    ramp_w = pr[16:0];
    ramp18 = {ramp_w[16], ramp_w};
    thr18  = $signed({2'b00, thr_r});
    sum18  = $signed({2'b00, old_r}) + ramp18;
    surge_w = (ramp18 >= thr18);
    fade_w  = (ramp18 <= -thr18);
    rmag    = ramp_w[16] ? 17'(-ramp_w) : 17'(ramp_w);
    sat_eff = (sat_r == '0) ? 16'd1 : sat_r;
  end

  // two restoring divide steps
  always_comb begin
    t1    = {rem_r, 1'b0};
    b1    = (t1 >= {1'b0, sat_eff});
    r1    = b1 ? (t1 - {1'b0, sat_eff}) : t1;
    t2    = {r1[15:0], 1'b0};
    b2    = (t2 >= {1'b0, sat_eff});
    r2    = b2 ? (t2 - {1'b0, sat_eff}) : t2;
    q_fin = {q_r[13:0], b1, b2};
    if (clamp_r) begin
      out_score_nxt = neg_r ? erd_pkg::SCORE_MIN : erd_pkg::SCORE_MAX;
    end else if (neg_r) begin
      out_score_nxt = 16'(-$signed({1'b0, q_fin[15:1]}));
    end else begin
      out_score_nxt = $signed({1'b0, q_fin[15:1]});
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    avg_nxt        = avg_r;
    last_surge_nxt = last_surge_r;
    last_fade_nxt  = last_fade_r;
    obs_nxt        = obs_r;
    old_nxt        = old_r;
    d_nxt          = d_r;
    asr_nxt        = asr_r;
    acc_hi_nxt     = acc_hi_r;
    lo_nxt         = lo_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    clamp_nxt      = clamp_r;
    neg_nxt        = neg_r;
    res_ramp_nxt   = res_ramp_r;
    res_surge_nxt  = res_surge_r;
    res_fade_nxt   = res_fade_r;
    res_sev_nxt    = res_sev_r;
    res_fev_nxt    = res_fev_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          old_nxt    = old_sel;
          d_nxt      = $signed({2'b00, in_mag[15:0]}) - $signed({2'b00, old_sel});
          asr_nxt    = {1'b0, alpha_r};
          acc_hi_nxt = '0;
          lo_nxt     = '0;
          cnt_nxt    = MUL_LAST;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        acc_hi_nxt = p >>> 2;
        lo_nxt     = {p[1:0], lo_r[2]};
        asr_nxt    = {2'b00, asr_r[17:2]};
        cnt_nxt    = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        avg_nxt        = sum18[15:0];
        obs_nxt        = obs_r + 32'd1;
        last_surge_nxt = surge_w;
        last_fade_nxt  = fade_w;
        res_ramp_nxt   = ramp_w;
        res_surge_nxt  = surge_w;
        res_fade_nxt   = fade_w;
        res_sev_nxt    = surge_w && !last_surge_r;
        res_fev_nxt    = fade_w && !last_fade_r;
        clamp_nxt      = (rmag >= {1'b0, sat_eff});
        neg_nxt        = ramp_w[16];
        rem_nxt        = rmag[15:0];
        q_nxt          = '0;
        cnt_nxt        = DIV_LAST;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        // hold the last step while the previous result is still waiting
        if (cnt_r != '0 || out_load) begin
          rem_nxt = r2[15:0];
          q_nxt   = q_fin;
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    alpha_wr = (cfg_wdata > erd_pkg::ALPHA_ONE) ? erd_pkg::ALPHA_ONE : cfg_wdata;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      alpha_r      <= erd_pkg::ALPHA_RST;
      sat_r        <= erd_pkg::SAT_RST;
      thr_r        <= erd_pkg::THR_RST;
      avg_r        <= '0;
      seeded_r     <= 1'b0;
      last_surge_r <= 1'b0;
      last_fade_r  <= 1'b0;
      obs_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      avg_r        <= avg_nxt;
      last_surge_r <= last_surge_nxt;
      last_fade_r  <= last_fade_nxt;
      obs_r        <= obs_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_acc) begin
        seeded_r <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          erd_pkg::REG_ALPHA: alpha_r <= alpha_wr;
          erd_pkg::REG_SAT:   sat_r   <= cfg_wdata[15:0];
          erd_pkg::REG_THR:   thr_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    old_r       <= old_nxt;
    d_r         <= d_nxt;
    asr_r       <= asr_nxt;
    acc_hi_r    <= acc_hi_nxt;
    lo_r        <= lo_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    clamp_r     <= clamp_nxt;
    neg_r       <= neg_nxt;
    res_ramp_r  <= res_ramp_nxt;
    res_surge_r <= res_surge_nxt;
    res_fade_r  <= res_fade_nxt;
    res_sev_r   <= res_sev_nxt;
    res_fev_r   <= res_fev_nxt;
    if (out_load) begin
      out_int_r   <= avg_r;
      out_ramp_r  <= res_ramp_r;
      out_score_r <= out_score_nxt;
      out_surge_r <= res_surge_r;
      out_fade_r  <= res_fade_r;
      out_sev_r   <= res_sev_r;
      out_fev_r   <= res_fev_r;
      out_cnt_r   <= obs_r;
    end
  end

`ifndef SYNTHESIS
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_int_r <= 16'd32768))
    else $error("average out of range");

  a_both_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_surge_r && out_fade_r) |-> (out_ramp_r == '0))
    else $error("surge and fade together on a non-zero ramp");

  a_score_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ramp_r == '0) |-> (out_score_r == '0))
    else $error("non-zero score on a flat ramp");

  a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_sev_r || out_surge_r) && (!out_fev_r || out_fade_r)))
    else $error("edge event without its level flag");
`endif

endmodule
